/* rtl/tcll_pkg.sv */
package tcll_pkg;

  localparam int CoordW = 16;
  localparam int SumW = 18;
  localparam int LatW = 16;
  localparam int LonW = 17;
  localparam int CordW = 52;
  localparam int AngW = 36;
  localparam int Steps = 28;
  localparam int SqW = 38;
  localparam int SqSteps = 48;
  localparam int RoundShift = 16;

  localparam logic signed [AngW-1:0] Deg180 = AngW'(64'sd180 <<< 24);
  localparam logic signed [LatW-1:0] LatMax = LatW'(90 * 256);
  localparam logic [LonW-1:0] LonFull = LonW'(360 * 256);

  function automatic logic signed [AngW-1:0] atan_tbl(input int i);
    logic signed [AngW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 36'sd754974720;
      1: r = 36'sd445687602;
      2: r = 36'sd235489088;
      3: r = 36'sd119537938;
      4: r = 36'sd60000934;
      5: r = 36'sd30029717;
      6: r = 36'sd15018523;
      7: r = 36'sd7509720;
      8: r = 36'sd3754917;
      9: r = 36'sd1877466;
      10: r = 36'sd938734;
      11: r = 36'sd469367;
      12: r = 36'sd234684;
      13: r = 36'sd117342;
      14: r = 36'sd58671;
      15: r = 36'sd29335;
      16: r = 36'sd14668;
      17: r = 36'sd7334;
      18: r = 36'sd3667;
      19: r = 36'sd1833;
      20: r = 36'sd917;
      21: r = 36'sd458;
      22: r = 36'sd229;
      23: r = 36'sd115;
      24: r = 36'sd57;
      25: r = 36'sd29;
      26: r = 36'sd14;
      27: r = 36'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [LatW+1:0] round_angle(input logic signed [AngW-1:0] a);
    logic [AngW-1:0] m;
    logic [AngW-1:0] q;
    m = a[AngW-1] ? AngW'(-a) : a;
    q = (m + AngW'(1 << (RoundShift - 1))) >> RoundShift;
    return a[AngW-1] ? -($signed((LatW+2)'(q))) : $signed((LatW+2)'(q));
  endfunction

endpackage

/* rtl/tcll_if.sv */
interface tcll_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tcll_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] latitude;
  logic [16:0] longitude;
  logic degenerate;
  modport source (output valid, latitude, longitude, degenerate, input ready);
  modport sink (input valid, latitude, longitude, degenerate, output ready);
endinterface

/* rtl/triangle_centroid_lat_lon.sv */
// channel | dir | payload                                   | handshake
// req     | in  | a_x..c_z, nine signed q2.14 coordinates    | valid/ready
// result  | out | latitude, longitude, degenerate           | valid/ready
//
// one request per cycle while the output is not stalled; the pipe is 1 sum +
// 1 square + 48 root + 28 cordic + 1 round stage, set by the bit-per-stage
// square root and the two 28-step cordic pipelines side by side
// rst clears only the stage valid bits
// the whole pipe advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated
module triangle_centroid_lat_lon (
  input logic clk,
  input logic rst,
  tcll_in_if.sink req,
  tcll_out_if.source result
);
  import tcll_pkg::*;

  localparam int NS = 2 + SqSteps + Steps;  // sum, square, root, cordic

  logic adv;
  assign adv = !result.valid || result.ready;
  assign req.ready = adv;

  // stage valid bits
  logic [NS-1:0] vld;

  // sum stage
  logic signed [SumW-1:0] sx, sy, sz;
  // square stage
  logic [SqW-1:0] hsq;
  logic signed [SumW-1:0] qx, qy, qz;

  // root pipeline: remainder / root / bit per stage
  logic [63:0] rv [SqSteps+1];
  logic [31:0] rr [SqSteps+1];
  logic signed [SumW-1:0] rx [SqSteps+1], ry [SqSteps+1], rz [SqSteps+1];

  // cordic pipelines for lat and lon
  logic signed [CordW-1:0] lx [Steps+1], ly [Steps+1];
  logic signed [CordW-1:0] gx [Steps+1], gy [Steps+1];
  logic signed [AngW-1:0] la [Steps+1], ga [Steps+1];
  logic signed [AngW-1:0] goff [Steps+1];
  logic dg [Steps+1];
  logic signed [SumW-1:0] dy [Steps+1];

  // sum and square
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= SumW'(req.a_x) + SumW'(req.b_x) + SumW'(req.c_x);
      sy <= SumW'(req.a_y) + SumW'(req.b_y) + SumW'(req.c_y);
      sz <= SumW'(req.a_z) + SumW'(req.b_z) + SumW'(req.c_z);
      hsq <= SqW'(SqW'(sx) * SqW'(sx)) + SqW'(SqW'(sz) * SqW'(sz));
      qx <= sx;
      qy <= sy;
      qz <= sz;
    end
  end

  // restoring square root of hsq << 28, one result bit per stage
  assign rv[0] = 64'(hsq) << 28;
  assign rr[0] = '0;
  assign rx[0] = qx;
  assign ry[0] = qy;
  assign rz[0] = qz;

  genvar g;
  generate
    for (g = 0; g < SqSteps; g++) begin : g_root
      logic [63:0] v_q;
      logic [31:0] r_q;
      logic signed [SumW-1:0] x_q, y_q, z_q;
      if (g < 16) begin : g_idle
        // bits above the reach of the radicand
        always_ff @(posedge clk) begin
          if (adv) begin
            v_q <= rv[g];
            r_q <= rr[g];
            x_q <= rx[g];
            y_q <= ry[g];
            z_q <= rz[g];
          end
        end
      end else begin : g_bit
        localparam int BB = 2 * (31 - (g - 16));
        logic [64:0] t;
        // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
        assign t = {1'b0, rv[g]} - ((65'(rr[g]) << (BB / 2 + 1)) + (65'd1 << BB));
        always_ff @(posedge clk) begin
          if (adv) begin
            if (!t[64]) begin
              v_q <= t[63:0];
              r_q <= rr[g] | (32'd1 << (BB / 2));
            end else begin
              v_q <= rv[g];
              r_q <= rr[g];
            end
            x_q <= rx[g];
            y_q <= ry[g];
            z_q <= rz[g];
          end
        end
      end
      assign rv[g+1] = v_q;
      assign rr[g+1] = r_q;
      assign rx[g+1] = x_q;
      assign ry[g+1] = y_q;
      assign rz[g+1] = z_q;
    end
  endgenerate

  // cordic inputs; the lon path folds x < 0 into the right half plane
  logic signed [SumW-1:0] fx, fy, fz;
  assign fx = rx[SqSteps];
  assign fy = ry[SqSteps];
  assign fz = rz[SqSteps];

  assign lx[0] = CordW'({1'b0, rr[SqSteps]}) <<< 16;
  assign ly[0] = CordW'(fy) <<< 30;
  assign la[0] = '0;
  assign gx[0] = (fx < 0) ? -(CordW'(fx) <<< 30) : (CordW'(fx) <<< 30);
  assign gy[0] = (fx < 0) ? -(CordW'(fz) <<< 30) : (CordW'(fz) <<< 30);
  assign goff[0] = (fx < 0) ? ((fz >= 0) ? Deg180 : -Deg180) : '0;
  assign ga[0] = '0;
  assign dg[0] = (fx == 0) && (fz == 0);
  assign dy[0] = fy;

  generate
    for (g = 0; g < Steps; g++) begin : g_cord
      logic signed [CordW-1:0] lx_q, ly_q, gx_q, gy_q;
      logic signed [AngW-1:0] la_q, ga_q, go_q;
      logic dg_q;
      logic signed [SumW-1:0] dy_q;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!ly[g][CordW-1]) begin
            lx_q <= lx[g] + (ly[g] >>> g);
            ly_q <= ly[g] - (lx[g] >>> g);
            la_q <= la[g] + atan_tbl(g);
          end else begin
            lx_q <= lx[g] - (ly[g] >>> g);
            ly_q <= ly[g] + (lx[g] >>> g);
            la_q <= la[g] - atan_tbl(g);
          end
          if (!gy[g][CordW-1]) begin
            gx_q <= gx[g] + (gy[g] >>> g);
            gy_q <= gy[g] - (gx[g] >>> g);
            ga_q <= ga[g] + atan_tbl(g);
          end else begin
            gx_q <= gx[g] - (gy[g] >>> g);
            gy_q <= gy[g] + (gx[g] >>> g);
            ga_q <= ga[g] - atan_tbl(g);
          end
          go_q <= goff[g];
          dg_q <= dg[g];
          dy_q <= dy[g];
        end
      end
      assign lx[g+1] = lx_q;
      assign ly[g+1] = ly_q;
      assign la[g+1] = la_q;
      assign gx[g+1] = gx_q;
      assign gy[g+1] = gy_q;
      assign ga[g+1] = ga_q;
      assign goff[g+1] = go_q;
      assign dg[g+1] = dg_q;
      assign dy[g+1] = dy_q;
    end
  endgenerate

  // rounding, saturation and wrap into the output register
  logic signed [LatW+1:0] lat_r, lon_r;
  logic signed [LatW-1:0] lat_next;
  logic [LonW-1:0] lon_next;

  always_comb begin
    lat_r = round_angle(la[Steps]);
    lon_r = round_angle(Deg180 - (ga[Steps] + goff[Steps]));
    if (dg[Steps]) begin
      lat_next = (dy[Steps] > 0) ? LatMax : ((dy[Steps] < 0) ? -LatMax : '0);
      lon_next = '0;
    end else begin
      if (lat_r > (LatW+2)'(LatMax)) begin
        lat_next = LatMax;
      end else if (lat_r < -(LatW+2)'(LatMax)) begin
        lat_next = -LatMax;
      end else begin
        lat_next = lat_r[LatW-1:0];
      end
      if (lon_r < 0) begin
        lon_next = LonW'(lon_r + (LatW+2)'(LonFull));
      end else if (lon_r >= (LatW+2)'(LonFull)) begin
        lon_next = LonW'(lon_r - (LatW+2)'(LonFull));
      end else begin
        lon_next = LonW'(lon_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.latitude <= lat_next;
      result.longitude <= lon_next;
      result.degenerate <= dg[Steps];
    end
  end

endmodule

/* rtl/tcll_checker.sv */
module tcll_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] latitude,
  input logic [16:0] longitude,
  input logic degenerate
);
  import tcll_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(latitude))
    else $error("result dropped under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");

  a_lon_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longitude < LonFull)
    else $error("longitude out of range");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> longitude == '0)
    else $error("degenerate longitude nonzero");

endmodule

bind triangle_centroid_lat_lon tcll_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(req.ready), .out_valid(result.valid),
  .out_ready(result.ready), .latitude(result.latitude),
  .longitude(result.longitude), .degenerate(result.degenerate)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tcll_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tcll_in_if req (.clk(clk));
  tcll_out_if result (.clk(clk));

  triangle_centroid_lat_lon dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .result(result.source)
  );

  // one triangle: three vertices, nine signed q2.14 coordinates
  typedef struct {
    logic signed [CoordW-1:0] c[9];
  } tri_t;

  // one centroid direction as the block should report it
  typedef struct {
    logic signed [LatW-1:0] lat;
    logic [LonW-1:0] lon;
    logic degen;
  } angles_t;

  // per-step arctangent in degrees with 24 fraction bits
  localparam longint AtanDeg[28] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };
  localparam longint DegOne = 64'sd1 << 24;
  localparam longint LatLimit = 90 * 256;
  localparam longint TurnFull = 360 * 256;
  localparam longint SpanCycles = 400000;

  tri_t pending_tris[$];
  angles_t expected_angles[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int degen_seen = 0;
  longint cycle = 0;
  int drv_gap = 0;
  int mon_gap = 0;
  bit calm = 1'b0;

  // floor shift for negative values too
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring cordic, atan2(y, x) for x >= 0 in degrees q.24
  function automatic longint atan2_deg(longint x, longint y);
    longint acc;
    longint nx;
    acc = 0;
    for (int i = 0; i < 28; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        acc += AtanDeg[i];
      end else begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        acc -= AtanDeg[i];
      end
      x = nx;
    end
    return acc;
  endfunction

  // q.24 degrees to q.8, halves away from zero
  function automatic longint to_q8(longint a);
    if (a >= 0) return (a + (64'sd1 << 15)) >>> 16;
    return -((-a + (64'sd1 << 15)) >>> 16);
  endfunction

  function automatic angles_t centroid_angles(tri_t t);
    angles_t r;
    longint x, y, z, lat, lon, a;
    longint unsigned ax, az;
    x = longint'(t.c[0]) + longint'(t.c[3]) + longint'(t.c[6]);
    y = longint'(t.c[1]) + longint'(t.c[4]) + longint'(t.c[7]);
    z = longint'(t.c[2]) + longint'(t.c[5]) + longint'(t.c[8]);
    if (x == 0 && z == 0) begin
      // pole or zero vector: longitude undefined, latitude from sign of y
      r.degen = 1'b1;
      lon = 0;
      lat = (y > 0) ? LatLimit : ((y < 0) ? -LatLimit : 0);
    end else begin
      r.degen = 1'b0;
      ax = (x < 0) ? -x : x;
      az = (z < 0) ? -z : z;
      lat = to_q8(atan2_deg(int_sqrt((ax * ax + az * az) << 28) * 65536, y * (64'sd1 << 30)));
      if (lat > LatLimit) lat = LatLimit;
      if (lat < -LatLimit) lat = -LatLimit;
      if (x < 0) begin
        a = atan2_deg(-x * (64'sd1 << 30), -z * (64'sd1 << 30));
        a += (z >= 0) ? 180 * DegOne : -180 * DegOne;
      end else begin
        a = atan2_deg(x * (64'sd1 << 30), z * (64'sd1 << 30));
      end
      lon = to_q8(180 * DegOne - a);
      while (lon >= TurnFull) lon -= TurnFull;
      while (lon < 0) lon += TurnFull;
    end
    r.lat = lat[LatW-1:0];
    r.lon = lon[LonW-1:0];
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_tri(input logic signed [CoordW-1:0] v[9]);
    tri_t t;
    for (int i = 0; i < 9; i++) t.c[i] = v[i];
    pending_tris = {pending_tris, t};
  endtask

  // stimulus: directed corners first, then random triangles
  initial begin
    logic signed [CoordW-1:0] v[9];
    tri_t t;
    // zero centroid
    v = '{default: 16'sd0};
    push_tri(v);
    // north and south poles
    v = '{0, 16384, 0, 0, 16384, 0, 0, 16384, 0};
    push_tri(v);
    v = '{0, -16384, 0, 0, -16384, 0, 0, -16384, 0};
    push_tri(v);
    // pole after cancellation in x and z
    v = '{100, 5, -7, -50, 5, 3, -50, 5, 4};
    push_tri(v);
    // all fields at the positive and negative extremes
    v = '{default: 16'sh7fff};
    push_tri(v);
    v = '{default: 16'sh8000};
    push_tri(v);
    // cardinal directions in the equatorial plane
    v = '{16384, 0, 0, 0, 0, 0, 0, 0, 0};
    push_tri(v);
    v = '{-16384, 0, 0, 0, 0, 0, 0, 0, 0};
    push_tri(v);
    v = '{0, 0, 16384, 0, 0, 0, 0, 0, 0};
    push_tri(v);
    v = '{0, 0, -16384, 0, 0, 0, 0, 0, 0};
    push_tri(v);
    // negative x with z just either side of zero, longitude near the wrap
    v = '{-32768, 0, -1, -32768, 0, 0, -32768, 0, 0};
    push_tri(v);
    v = '{-32768, 0, 1, -32768, 0, 0, -32768, 0, 0};
    push_tri(v);
    // southern points keep negative latitude
    v = '{16384, -16384, 16384, 0, 0, 0, 0, 0, 0};
    push_tri(v);
    v = '{-1, -32768, 1, -1, -32768, 0, 0, -32768, 0};
    push_tri(v);
    // tiny x against huge y, latitude close to the limit
    v = '{1, 32767, 0, 0, 32767, 0, 0, 32767, 0};
    push_tri(v);
    v = '{1, -32768, 0, 0, -32768, 0, 0, -32768, 0};
    push_tri(v);
    v = '{32767, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767};
    push_tri(v);
    // random triangles, mostly full range, some with small sums
    repeat (2000) begin
      for (int i = 0; i < 9; i++) t.c[i] = rand_coord();
      pending_tris = {pending_tris, t};
    end
  end

  // driver: present the head of the queue, random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        void'(pending_tris.pop_front());
        sent <= sent + 1;
      end
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        if (!(req.valid && !req.ready)) req.valid <= 1'b0;
      end else if (!(req.valid && !req.ready)) begin
        if (!calm && $urandom_range(0, 15) == 0) begin
          drv_gap <= $urandom_range(1, 11) - 1;
          req.valid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          t_load();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // load the next pending triangle onto the bus and record its prediction
  task automatic t_load();
    tri_t t;
    t = pending_tris[0];
    req.valid <= 1'b1;
    req.a_x <= t.c[0]; req.a_y <= t.c[1]; req.a_z <= t.c[2];
    req.b_x <= t.c[3]; req.b_y <= t.c[4]; req.b_z <= t.c[5];
    req.c_x <= t.c[6]; req.c_y <= t.c[7]; req.c_z <= t.c[8];
    expected_angles = {expected_angles, centroid_angles(t)};
  endtask

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    angles_t e;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        received <= received + 1;
        if (expected_angles.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_angles.pop_front();
          if (result.degenerate) degen_seen++;
          if (result.latitude !== e.lat) begin
            $error("latitude expected %0d got %0d", e.lat, result.latitude);
            errors++;
          end
          if (result.longitude !== e.lon) begin
            $error("longitude expected %0d got %0d", e.lon, result.longitude);
            errors++;
          end
          if (result.degenerate !== e.degen) begin
            $error("degenerate expected %0d got %0d", e.degen, result.degenerate);
            errors++;
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        result.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        mon_gap <= $urandom_range(1, 11) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // quiet last stretch with no idling on either side
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && pending_tris.size() < 200) calm <= 1'b1;
    if (cycle > SpanCycles) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.a_x = '0; req.a_y = '0; req.a_z = '0;
    req.b_x = '0; req.b_y = '0; req.b_z = '0;
    req.c_x = '0; req.c_y = '0; req.c_z = '0;
    result.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // wait for stimulus to drain, then for the pipe to settle
    wait (pending_tris.size() == 0 && !req.valid);
    wait (expected_angles.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d triangles, %0d results, %0d poles or zero centroids",
             sent, received, degen_seen);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcll_pkg.sv
rtl/tcll_if.sv
rtl/triangle_centroid_lat_lon.sv
rtl/tcll_checker.sv
tb/tb.sv
